[src/assert_macros.svh]
// Assertion helpers shared by the RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Same-cycle implication, sampled on clk, off during reset.
`define ASSERT_IMPLIES(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
// Next-cycle implication, sampled on clk, off during reset.
`define ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);
`else
`define ASSERT_IMPLIES(lbl, ante, cons, msg)
`define ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

[src/pfvf_pkg.sv]
package pfvf_pkg;

  localparam int VALUE_W      = 64;
  localparam int DEC_BITS     = 32;
  localparam int NIBBLES      = VALUE_W / 4;
  localparam int NDIG_W       = 5;
  localparam int WIDTH_W      = 6;
  localparam int RESULT_LIMIT = 32;

  // conversion kinds
  localparam logic [2:0] FUNC_SDEC = 3'd0;
  localparam logic [2:0] FUNC_UDEC = 3'd1;
  localparam logic [2:0] FUNC_HEX  = 3'd2;
  localparam logic [2:0] FUNC_PTR  = 3'd3;
  localparam logic [2:0] FUNC_CHAR = 3'd4;

  localparam logic [7:0] CH_ZERO  = 8'h30;
  localparam logic [7:0] CH_MINUS = 8'h2d;
  localparam logic [7:0] CH_X     = 8'h78;
  localparam logic [7:0] CH_BANG  = 8'h21;

  localparam logic [7:0] HEX_DIGITS [16] = '{
    8'h30, 8'h31, 8'h32, 8'h33, 8'h34, 8'h35, 8'h36, 8'h37,
    8'h38, 8'h39, 8'h61, 8'h62, 8'h63, 8'h64, 8'h65, 8'h66
  };

  typedef enum logic [1:0] {
    KIND_NUM,
    KIND_CHAR,
    KIND_BAD
  } kind_t;

  typedef enum logic [1:0] {
    PFX_NONE,
    PFX_MINUS,
    PFX_HEX
  } prefix_t;

  typedef struct packed {
    logic [2:0]         func;
    logic [VALUE_W-1:0] value;
    logic               zero_pad;
    logic [WIDTH_W-1:0] min_width;
  } in_word_t;

  typedef struct packed {
    logic [7:0] char_out;
    logic       last;
  } out_word_t;

  // digit unit -> emitter handoff; digits MSD in the top nibble,
  // a char kind carries its byte in the low 8 bits
  typedef struct packed {
    logic               valid;
    kind_t              kind;
    prefix_t            prefix;
    logic [VALUE_W-1:0] digits;
    logic [NDIG_W-1:0]  num_digits;
    logic [WIDTH_W-1:0] pad_width;
  } dig_res_t;

  typedef struct packed {
    logic busy;
    logic take;
  } emit_stat_t;

  function automatic logic [7:0] digit_char(input logic [3:0] nib);
    return HEX_DIGITS[nib];
  endfunction

endpackage

[src/pfvf_digits.sv]
module pfvf_digits #(
  parameter int MAX_WIDTH    = 32,
  parameter int POINTER_BITS = 64
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  pfvf_pkg::in_word_t in_word,
  input  logic               take,
  output pfvf_pkg::dig_res_t res
);
  import pfvf_pkg::*;

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_CONV = 4'b0010,
    S_SKIP = 4'b0100,
    S_DONE = 4'b1000
  } state_t;

  localparam int WCAP = (MAX_WIDTH < RESULT_LIMIT) ? MAX_WIDTH : RESULT_LIMIT;
  localparam logic [WIDTH_W-1:0] WCAP_V = WIDTH_W'(WCAP);
  localparam logic [VALUE_W-1:0] PTR_MASK = {VALUE_W{1'b1}} >> (VALUE_W - POINTER_BITS);
  localparam logic [NDIG_W-1:0] NDIG_FULL = NDIG_W'(NIBBLES);

  state_t              state_r, state_nxt;
  logic [DEC_BITS-1:0] val_r, val_nxt;
  logic [VALUE_W-1:0]  dig_r, dig_nxt;
  logic [4:0]          bit_cnt_r, bit_cnt_nxt;
  logic [NDIG_W-1:0]   nd_r, nd_nxt;
  kind_t               kind_r, kind_nxt;
  prefix_t             pfx_r, pfx_nxt;
  logic [WIDTH_W-1:0]  pad_r, pad_nxt;

  logic [DEC_BITS-1:0] word_lo, mag;
  logic                neg;
  logic [WIDTH_W-1:0]  pad_ld;
  logic [VALUE_W-1:0]  dabble;

  assign word_lo = in_word.value[DEC_BITS-1:0];
  assign neg     = (in_word.func == FUNC_SDEC) && word_lo[DEC_BITS-1];
  assign mag     = neg ? (DEC_BITS'(0) - word_lo) : word_lo;
  assign pad_ld  = !in_word.zero_pad ? '0 :
                   (in_word.min_width > WCAP_V) ? WCAP_V : in_word.min_width;

  // add-3 correction on every BCD nibble
  always_comb begin
    for (int k = 0; k < NIBBLES; k++) begin
      dabble[k*4 +: 4] = (dig_r[k*4 +: 4] >= 4'd5) ? dig_r[k*4 +: 4] + 4'd3
                                                   : dig_r[k*4 +: 4];
    end
  end

  always_comb begin
    state_nxt   = state_r;
    val_nxt     = val_r;
    dig_nxt     = dig_r;
    bit_cnt_nxt = bit_cnt_r;
    nd_nxt      = nd_r;
    kind_nxt    = kind_r;
    pfx_nxt     = pfx_r;
    pad_nxt     = pad_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          pad_nxt     = pad_ld;
          kind_nxt    = KIND_NUM;
          pfx_nxt     = PFX_NONE;
          nd_nxt      = NDIG_FULL;
          val_nxt     = mag;
          bit_cnt_nxt = 5'(DEC_BITS - 1);
          dig_nxt     = '0;
          unique case (in_word.func)
            FUNC_SDEC: begin
              pfx_nxt   = neg ? PFX_MINUS : PFX_NONE;
              state_nxt = S_CONV;
            end
            FUNC_UDEC: state_nxt = S_CONV;
            FUNC_HEX: begin
              dig_nxt   = VALUE_W'(word_lo);
              state_nxt = S_SKIP;
            end
            FUNC_PTR: begin
              dig_nxt   = in_word.value & PTR_MASK;
              pfx_nxt   = PFX_HEX;
              state_nxt = S_SKIP;
            end
            FUNC_CHAR: begin
              dig_nxt   = VALUE_W'(in_word.value[7:0]);
              kind_nxt  = KIND_CHAR;
              nd_nxt    = NDIG_W'(1);
              state_nxt = S_DONE;
            end
            default: begin
              kind_nxt  = KIND_BAD;
              nd_nxt    = NDIG_W'(1);
              pad_nxt   = '0;
              state_nxt = S_DONE;
            end
          endcase
        end
      end
      S_CONV: begin
        dig_nxt = {dabble[VALUE_W-2:0], val_r[DEC_BITS-1]};
        val_nxt = {val_r[DEC_BITS-2:0], 1'b0};
        if (bit_cnt_r == '0) begin
          state_nxt = S_SKIP;
        end else begin
          bit_cnt_nxt = bit_cnt_r - 5'd1;
        end
      end
      S_SKIP: begin
        // drop leading zero digits, keep at least one
        if ((dig_r[VALUE_W-1 -: 4] == 4'd0) && (nd_r != NDIG_W'(1))) begin
          dig_nxt = {dig_r[VALUE_W-5:0], 4'd0};
          nd_nxt  = nd_r - NDIG_W'(1);
        end else begin
          state_nxt = S_DONE;
        end
      end
      S_DONE: begin
        if (take) begin
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_ff @(posedge clk) begin
    val_r     <= val_nxt;
    dig_r     <= dig_nxt;
    bit_cnt_r <= bit_cnt_nxt;
    nd_r      <= nd_nxt;
    kind_r    <= kind_nxt;
    pfx_r     <= pfx_nxt;
    pad_r     <= pad_nxt;
  end

  assign in_stall = (state_r != S_IDLE);

  assign res.valid      = (state_r == S_DONE);
  assign res.kind       = kind_r;
  assign res.prefix     = pfx_r;
  assign res.digits     = dig_r;
  assign res.num_digits = nd_r;
  assign res.pad_width  = pad_r;

endmodule

[src/pfvf_emit.sv]
module pfvf_emit (
  input  logic                 clk,
  input  logic                 rst_n,
  input  pfvf_pkg::dig_res_t   res,
  output pfvf_pkg::emit_stat_t stat,
  output logic                 out_valid,
  input  logic                 out_stall,
  output pfvf_pkg::out_word_t  out_word
);
  import pfvf_pkg::*;

  typedef enum logic [1:0] {
    E_IDLE = 2'b01,
    E_RUN  = 2'b10
  } state_t;

  state_t             state_r, state_nxt;
  kind_t              kind_r, kind_nxt;
  prefix_t            pfx_r, pfx_nxt;
  logic [VALUE_W-1:0] dig_r, dig_nxt;
  logic [NDIG_W-1:0]  nd_r, nd_nxt;
  logic [WIDTH_W-1:0] pad_r, pad_nxt;
  logic [1:0]         pfx_cnt_r, pfx_cnt_nxt;
  logic               out_valid_r, out_valid_nxt;
  out_word_t          out_word_r, out_word_nxt;

  logic               take, advance, is_last;
  logic [1:0]         np;
  logic [WIDTH_W-1:0] body;
  logic [7:0]         ch;

  assign take    = (state_r == E_IDLE) && res.valid;
  assign advance = (state_r == E_RUN) && (!out_valid_r || !out_stall);

  always_comb begin
    unique case (res.prefix)
      PFX_MINUS: np = 2'd1;
      PFX_HEX:   np = 2'd2;
      default:   np = 2'd0;
    endcase
  end
  assign body = WIDTH_W'(res.num_digits) + WIDTH_W'(np);

  // pad zeros, then prefix, then digits
  always_comb begin
    is_last = 1'b0;
    if (pad_r != '0) begin
      ch = CH_ZERO;
    end else if (pfx_cnt_r != 2'd0) begin
      if (pfx_r == PFX_MINUS) begin
        ch = CH_MINUS;
      end else begin
        ch = (pfx_cnt_r == 2'd2) ? CH_ZERO : CH_X;
      end
    end else begin
      is_last = (nd_r == NDIG_W'(1));
      unique case (kind_r)
        KIND_NUM:  ch = digit_char(dig_r[VALUE_W-1 -: 4]);
        KIND_CHAR: ch = dig_r[7:0];
        default:   ch = CH_BANG;
      endcase
    end
  end

  always_comb begin
    state_nxt     = state_r;
    kind_nxt      = kind_r;
    pfx_nxt       = pfx_r;
    dig_nxt       = dig_r;
    nd_nxt        = nd_r;
    pad_nxt       = pad_r;
    pfx_cnt_nxt   = pfx_cnt_r;
    out_word_nxt  = out_word_r;
    out_valid_nxt = out_valid_r && out_stall;
    if (take) begin
      kind_nxt    = res.kind;
      pfx_nxt     = res.prefix;
      dig_nxt     = res.digits;
      nd_nxt      = res.num_digits;
      pfx_cnt_nxt = np;
      pad_nxt     = (res.pad_width > body) ? res.pad_width - body : '0;
      state_nxt   = E_RUN;
    end
    if (advance) begin
      out_valid_nxt         = 1'b1;
      out_word_nxt.char_out = ch;
      out_word_nxt.last     = is_last;
      if (pad_r != '0) begin
        pad_nxt = pad_r - WIDTH_W'(1);
      end else if (pfx_cnt_r != 2'd0) begin
        pfx_cnt_nxt = pfx_cnt_r - 2'd1;
      end else begin
        dig_nxt = {dig_r[VALUE_W-5:0], 4'd0};
        nd_nxt  = nd_r - NDIG_W'(1);
        if (is_last) begin
          state_nxt = E_IDLE;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= E_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r     <= kind_nxt;
    pfx_r      <= pfx_nxt;
    dig_r      <= dig_nxt;
    nd_r       <= nd_nxt;
    pad_r      <= pad_nxt;
    pfx_cnt_r  <= pfx_cnt_nxt;
    out_word_r <= out_word_nxt;
  end

  assign stat.busy = (state_r == E_RUN);
  assign stat.take = take;
  assign out_valid = out_valid_r;
  assign out_word  = out_word_r;

endmodule

[src/printf_value_formatter_unit.sv]
// Integer / character conversion formatter for debug print paths.
// in_ channel: one word per conversion (func, value, zero_pad, min_width),
//   taken when in_valid is high and in_stall is low.
// out_ channel: the ASCII characters of the field, most significant first,
//   one word per character; last marks the final character.
// After accept, a decimal word goes through bit-serial BCD conversion,
//   leading-zero digit skip and the handoff; hex and pointer words go through
//   the skip and the handoff, and char and bad kinds go straight to the
//   handoff.
// Then one character per cycle while the receiver does not stall; a field is at most 32 characters.
// The digit unit takes the next word as soon as its result has been handed to
//   the character emitter, so conversion overlaps emission of the prior field.
//   Sustained throughput is set by the serial conversion and skip, or by the
//   field length when that is longer.
// Reset (rst_n low, synchronous) drops any word in flight and clears
//   out_valid; in_stall is low after reset.
// When the receiver stalls, the output word holds and the emitter pauses;
//   in_stall stays high through each conversion and while a finished one
//   waits on the busy emitter.
`include "assert_macros.svh"

module printf_value_formatter_unit #(
  parameter int MAX_WIDTH    = 32,
  parameter int POINTER_BITS = 64
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  pfvf_pkg::in_word_t  in_word,
  output logic                out_valid,
  input  logic                out_stall,
  output pfvf_pkg::out_word_t out_word
);
  import pfvf_pkg::*;

  dig_res_t   dig_res;   // finished conversion, held until taken
  emit_stat_t emit_stat; // emitter busy / handoff strobe

  // Bit-serial conversion: double dabble for decimal, nibble shift for hex,
  // then a leading-zero digit skip.
  pfvf_digits #(
    .MAX_WIDTH    (MAX_WIDTH),
    .POINTER_BITS (POINTER_BITS)
  ) u_digits (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .take     (emit_stat.take),
    .res      (dig_res)
  );

  // Pad zeros, prefix and digits one per cycle, while the receiver does not stall, into the output register.
  pfvf_emit u_emit (
    .clk       (clk),
    .rst_n     (rst_n),
    .res       (dig_res),
    .stat      (emit_stat),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .out_word  (out_word)
  );

  // an accepted word keeps the digit unit busy on the next cycle
  `ASSERT_NEXT(a_accept_busy, in_valid && !in_stall, in_stall,
               "digit unit free right after accepting a word")
  // handoff starts the emitter and frees the digit unit
  `ASSERT_NEXT(a_handoff, emit_stat.take, emit_stat.busy && !in_stall,
               "handoff did not start emitter or free digit unit")
  // with the emitter idle, a taken word leaves the output empty
  `ASSERT_NEXT(a_no_extra_word, out_valid && !out_stall && !emit_stat.busy,
               !out_valid, "output word appeared with emitter idle")

endmodule

[tb/testbench.sv]
`timescale 1ns / 100ps

// Checks the printf value formatter: one conversion word in, a stream of ASCII
// character words out, last set on the final one of each field.
module testbench;
  import pfvf_pkg::*;

  // Instance parameters; the predictor follows the same values.
  localparam int MAX_W      = 32;
  localparam int PTR_BITS   = 64;
  localparam int FIELD_MAX  = 32;       // most characters one field can hold
  localparam int N_RANDOM   = 136;
  localparam int DRAIN_WAIT = 60;       // covers the slowest decimal latency
  localparam int CYCLE_LIMIT = 400000;
  localparam int REPORT_MAX = 10;

  // Kinds 5..7 are not defined by the package; one stands for all of them.
  localparam logic [2:0] FUNC_BAD = 3'd5;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_word_t  in_word = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_word_t out_word;

  printf_value_formatter_unit #(
    .MAX_WIDTH   (MAX_W),
    .POINTER_BITS(PTR_BITS)
  ) u_top (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_word  (in_word),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_word (out_word)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Characters still owed by the formatter, oldest first.
  out_word_t pending_chars[$];
  int unsigned error_count = 0;
  int unsigned cycle_count = 0;
  // While set, neither side inserts gaps: back-to-back traffic.
  bit quiet = 1'b0;

  // Directed rows. An empty text means: expectation comes from the predictor.
  typedef struct {
    logic [2:0]  func;
    logic [63:0] value;
    logic        zero_pad;
    logic [5:0]  min_width;
    string       text;
  } case_row_t;

  case_row_t directed_rows[$];

  function automatic logic [7:0] digit_ascii(input logic [3:0] d);
    return (d < 4'd10) ? 8'h30 + 8'(d) : 8'h61 + 8'(d) - 8'd10;
  endfunction

  // Digits of v in base, most significant first, at least one.
  function automatic void push_digits(input logic [63:0] v, input int unsigned base,
                                      ref logic [7:0] digs[$]);
    logic [63:0] rest;
    rest = v;
    do begin
      digs.push_front(digit_ascii(4'(rest % base)));
      rest = rest / base;
    end while (rest != 64'd0);
  endfunction

  // Predicts the character words of one conversion and queues them.
  function automatic void format_conversion(input in_word_t w);
    logic [7:0]  prefix[$];
    logic [7:0]  digs[$];
    logic [7:0]  field[$];
    logic [31:0] low32;
    logic [63:0] ptr_val;
    int unsigned cap;
    int unsigned width;
    out_word_t   c;
    low32 = w.value[31:0];
    case (w.func)
      FUNC_SDEC: begin
        if (low32[31]) begin
          // two's complement magnitude; 0x80000000 comes out as 2147483648
          prefix.push_back(CH_MINUS);
          push_digits({32'd0, ~low32 + 32'd1}, 10, digs);
        end else begin
          push_digits({32'd0, low32}, 10, digs);
        end
      end
      FUNC_UDEC: push_digits({32'd0, low32}, 10, digs);
      FUNC_HEX:  push_digits({32'd0, low32}, 16, digs);
      FUNC_PTR: begin
        ptr_val = w.value;
        if (PTR_BITS < 64) ptr_val = ptr_val & ((64'd1 << PTR_BITS) - 64'd1);
        push_digits(ptr_val, 16, digs);
        prefix.push_back(CH_ZERO);
        prefix.push_back(CH_X);
      end
      FUNC_CHAR: digs.push_back(w.value[7:0]);
      default: begin
        // unknown kind: a lone '!', no padding
        c.char_out = CH_BANG;
        c.last     = 1'b1;
        pending_chars.push_back(c);
        return;
      end
    endcase
    cap   = (MAX_W < FIELD_MAX) ? MAX_W : FIELD_MAX;
    width = (w.min_width > cap) ? cap : w.min_width;
    // zeros go in front of the sign or 0x prefix
    if (w.zero_pad) begin
      for (int unsigned i = prefix.size() + digs.size();
           i < width && field.size() < FIELD_MAX; i++)
        field.push_back(CH_ZERO);
    end
    foreach (prefix[i]) if (field.size() < FIELD_MAX) field.push_back(prefix[i]);
    foreach (digs[i]) if (field.size() < FIELD_MAX) field.push_back(digs[i]);
    foreach (field[i]) begin
      c.char_out = field[i];
      c.last     = (i == field.size() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  // Expectation typed into the table.
  function automatic void queue_text(input string text);
    out_word_t c;
    for (int i = 0; i < text.len(); i++) begin
      c.char_out = text[i];
      c.last     = (i == text.len() - 1);
      pending_chars.push_back(c);
    end
  endfunction

  function automatic void note_error(input string msg);
    error_count++;
    if (error_count <= REPORT_MAX) $display("ERROR @%0t: %s", $realtime, msg);
  endfunction

  function automatic in_word_t random_word();
    in_word_t w;
    // mostly real kinds, a few unknown ones
    w.func = ($urandom_range(0, 15) < 14) ? 3'($urandom_range(0, 4))
                                          : 3'($urandom_range(5, 7));
    case ($urandom_range(0, 3))
      0: w.value = {$urandom, $urandom};
      1: w.value = 64'($urandom_range(0, 20));
      2: case ($urandom_range(0, 3))
           0: w.value = 64'd0;
           1: w.value = '1;
           2: w.value = 64'h8000_0000;
           default: w.value = 64'h7fff_ffff;
         endcase
      default: w.value = {$urandom, $urandom} >> $urandom_range(0, 63);
    endcase
    w.zero_pad  = 1'($urandom);
    // widths mostly near the field lengths, sometimes anywhere incl. saturating
    w.min_width = ($urandom_range(0, 3) == 0) ? 6'($urandom_range(0, 63))
                                              : 6'($urandom_range(0, 20));
    return w;
  endfunction

  // Presents one word after a random gap and holds it until taken.
  // Returns at the accepting edge; valid stays high so a following
  // zero-gap word goes out without a bubble.
  task automatic send_word(input in_word_t w, input string text);
    int unsigned gap;
    gap = quiet ? 0 : $urandom_range(0, 5);
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_word  <= w;
    do @(posedge clk); while (in_stall);
    if (text.len() != 0) queue_text(text);
    else format_conversion(w);
  endtask

  // Receiver: after each taken word, draws a random stall length; no stalls while quiet.
  int unsigned stall_left = 0;
  always @(posedge clk) begin
    if (!rst_n) begin
      out_stall  <= 1'b0;
      stall_left <= 0;
    end else if (out_valid && !out_stall) begin
      stall_left <= quiet ? 0 : $urandom_range(0, 5);
      out_stall  <= !quiet && ($urandom_range(0, 1) == 1);
    end else if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_stall  <= (stall_left != 1);
    end else begin
      out_stall <= 1'b0;
    end
  end

  // Output checker: every taken word against the oldest expectation.
  always @(posedge clk) begin
    out_word_t exp_c;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_chars.size() == 0) begin
        note_error($sformatf("unexpected word char=%02h last=%0b",
                             out_word.char_out, out_word.last));
      end else begin
        exp_c = pending_chars.pop_front();
        if (out_word.char_out !== exp_c.char_out)
          note_error($sformatf("char_out exp %02h got %02h",
                               exp_c.char_out, out_word.char_out));
        if (out_word.last !== exp_c.last)
          note_error($sformatf("last exp %0b got %0b (char %02h)",
                               exp_c.last, out_word.last, exp_c.char_out));
      end
    end
  end

  // Watchdog.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("testbench: FAIL");
      $finish;
    end
  end

  initial begin
    in_word_t w;
    directed_rows = '{
      '{FUNC_SDEC, 64'd0,                  1'b0, 6'd0,  "0"},
      '{FUNC_SDEC, 64'h8000_0000,          1'b0, 6'd0,  "-2147483648"},
      '{FUNC_SDEC, 64'hffff_ffff,          1'b0, 6'd0,  "-1"},
      '{FUNC_SDEC, 64'h7fff_ffff,          1'b0, 6'd0,  "2147483647"},
      '{FUNC_UDEC, 64'hffff_ffff,          1'b0, 6'd0,  "4294967295"},
      '{FUNC_UDEC, 64'hffff_ffff_0000_0000, 1'b0, 6'd0, "0"},
      '{FUNC_HEX,  64'hdead_beef,          1'b0, 6'd0,  "deadbeef"},
      '{FUNC_HEX,  64'd0,                  1'b0, 6'd0,  "0"},
      '{FUNC_PTR,  '1,                     1'b0, 6'd0,  "0xffffffffffffffff"},
      '{FUNC_PTR,  64'd0,                  1'b0, 6'd0,  "0x0"},
      '{FUNC_CHAR, 64'hffff_ff41,          1'b0, 6'd0,  "A"},
      '{FUNC_CHAR, 64'hff00,               1'b1, 6'd3,  ""},   // NUL byte, padded
      '{FUNC_BAD,  64'd7,                  1'b0, 6'd0,  "!"},
      '{3'd6,      '1,                     1'b1, 6'd32, "!"},  // bad kind ignores pad
      '{3'd7,      64'd0,                  1'b1, 6'd63, "!"},
      '{FUNC_SDEC, 64'hffff_fffb,          1'b1, 6'd5,  "000-5"},
      '{FUNC_PTR,  64'd1,                  1'b1, 6'd6,  "0000x1"},
      '{FUNC_UDEC, 64'd7,                  1'b1, 6'd63, ""},   // width saturates
      '{FUNC_CHAR, 64'h7a,                 1'b1, 6'd32, ""},
      '{FUNC_HEX,  64'hab,                 1'b0, 6'd20, "ab"}, // pad off
      '{FUNC_SDEC, 64'd12,                 1'b1, 6'd0,  "12"},
      '{FUNC_PTR,  64'd0,                  1'b1, 6'd1,  "0x0"},
      '{FUNC_HEX,  64'hffff_ffff,          1'b1, 6'd33, ""},
      '{FUNC_SDEC, 64'h8000_0000,          1'b1, 6'd20, ""}
    };
    repeat (2) @(posedge clk);
    rst_n <= 1'b1;

    foreach (directed_rows[i]) begin
      w.func      = directed_rows[i].func;
      w.value     = directed_rows[i].value;
      w.zero_pad  = directed_rows[i].zero_pad;
      w.min_width = directed_rows[i].min_width;
      send_word(w, directed_rows[i].text);
    end

    // random part, with a back-to-back stretch in the middle
    for (int k = 0; k < N_RANDOM; k++) begin
      quiet = (k >= 60 && k < 100);
      send_word(random_word(), "");
    end
    quiet = 1'b0;
    in_valid <= 1'b0;

    while (pending_chars.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);

    if (error_count == 0) begin
      $display("testbench: PASS");
    end else begin
      $display("testbench: FAIL");
    end
    $finish;
  end

endmodule
